// ===== src/rtoe_pkg.sv =====
// Package for the two-objective Rastrigin evaluator: payload types, constants and
// the quarter-wave sine polynomial coefficients. No dependencies.
`default_nettype none
package rtoe_pkg;
	localparam int MAX_VARS  = 1024;
	localparam int FRAC_BITS = 12;
	localparam int CNT_W     = $clog2(MAX_VARS + 1);
	localparam int SUM_W     = 32;
	localparam int ROOT_SH   = 56 - FRAC_BITS;

	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [15:0] SIN_B = 16'd42334;
	localparam logic [12:0] SIN_C = 13'd5223;
	localparam logic [8:0]  SIN_D = 9'd307;

	typedef struct packed {
		logic signed [15:0] x_value;
		logic               is_last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] obj_first;
		logic [15:0] obj_second;
		logic        overflow;
	} out_item_t;

	// closed vector handed from the accumulator to the finishing unit
	typedef struct packed {
		logic [SUM_W-1:0] sum_plain;
		logic [SUM_W-1:0] sum_shifted;
		logic [CNT_W-1:0] count;
		logic             saturated;
	} vec_sums_t;
endpackage
`default_nettype wire

// ===== src/rtoe_term.sv =====
// Rastrigin term of one variable, five register stages.
// Depends on rtoe_pkg.
`default_nettype none
module rtoe_term (
	input  wire                   clk,
	input  wire signed [17:0]     y,
	output logic [33:0]           term
);
	import rtoe_pkg::*;

	logic [17:0] mag;
	logic [15:0] p;
	logic [14:0] u_c;
	logic [29:0] u2_full;
	// stage 1
	logic [14:0] u_s1;
	logic [1:0]  q_s1;
	logic [33:0] sq_s1;
	// stage 2
	logic [14:0] u_s2, u2_s2;
	logic [1:0]  q_s2;
	logic [33:0] sq_s2;
	logic [13:0] t1_s2;
	// stage 3
	logic [14:0] u_s3, u2_s3;
	logic [1:0]  q_s3;
	logic [33:0] sq_s3;
	logic [16:0] t2_s3;
	// stage 4
	logic [14:0] u_s4;
	logic [1:0]  q_s4;
	logic [33:0] sq_s4;
	logic [17:0] t3_s4;
	logic [31:0] m2, m3;
	logic [33:0] m4;
	logic [17:0] s_c;
	logic signed [15:0] cos_c;
	logic [18:0] wave;
	logic [36:0] wsh;

	assign mag = y[17] ? 18'(-y) : 18'(y);
	assign p = 16'(({4'd0, y[FRAC_BITS-1:0]} << (16 - FRAC_BITS)) + 16'd16384);
	assign u_c = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
	assign u2_full = u_s1 * u_s1;

	always_ff @(posedge clk) begin
		u_s1  <= u_c;
		q_s1  <= p[15:14];
		sq_s1 <= 34'((36'(mag) * 36'(mag)) >> FRAC_BITS);
		u_s2  <= u_s1;
		q_s2  <= q_s1;
		sq_s2 <= sq_s1;
		u2_s2 <= u2_full[28:14];
		t1_s2 <= 14'(14'(SIN_C) - 14'((u2_full[28:14] * 24'(SIN_D)) >> 14));
		u_s3  <= u_s2;
		q_s3  <= q_s2;
		sq_s3 <= sq_s2;
		u2_s3 <= u2_s2;
		t2_s3 <= 17'(17'(SIN_B) - 17'(m2 >> 14));
		u_s4  <= u_s3;
		q_s4  <= q_s3;
		sq_s4 <= sq_s3;
		t3_s4 <= 18'(18'(SIN_A) - 18'(m3 >> 14));
		term  <= 34'(sq_s4 + 34'(wsh >> 14));
	end

	assign m2 = 32'(u2_s2) * 32'(t1_s2);
	assign m3 = 32'(u2_s3) * 32'(t2_s3);
	assign m4 = 34'(u_s4) * 34'(t3_s4);
	assign s_c = (m4[33:16] > 18'd16384) ? 18'd16384 : m4[33:16];
	assign cos_c = q_s4[1] ? -16'(s_c) : 16'(s_c);
	assign wave = 19'(19'd10 * 19'(17'sd16384 - 17'(cos_c)));
	assign wsh = 37'(wave) << FRAC_BITS;
endmodule
`default_nettype wire

// ===== src/rtoe_front.sv =====
// Front end: accepts variables, computes both terms and keeps the running sums;
// a closed vector is pushed to a two-entry queue. Depends on rtoe_pkg, rtoe_term.
`default_nettype none
module rtoe_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   valid,
	output logic                  stall,
	input  rtoe_pkg::in_item_t    data,
	output logic                  q_valid,
	input  wire                   q_pop,
	output rtoe_pkg::vec_sums_t   q_data
);
	import rtoe_pkg::*;
	localparam int LAT = 5;

	logic              acc;
	logic [LAT-1:0]    v_sh_q, l_sh_q;
	logic [33:0]       tp, ts;
	logic [SUM_W-1:0]  sp_q, ss_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sat_q;
	logic [1:0]        fill_q;
	logic [2:0]        inflight;
	vec_sums_t         ent_q [2];
	logic              rd_q, wr_q;
	logic [SUM_W-1:0]  sp_n, ss_n;
	logic [CNT_W-1:0]  cnt_n;
	logic              sat_n, push;
	logic [34:0]       ap, as_;

	// stall while queue could not absorb every closing item in flight
	always_comb begin
		inflight = 3'(fill_q) + 3'($countones(v_sh_q & l_sh_q));
	end
	assign stall = (inflight >= 3'd2);
	assign acc = valid && !stall;

	rtoe_term u_tp (.clk(clk), .y(18'(data.x_value)), .term(tp));
	rtoe_term u_ts (.clk(clk),
		.y(18'(18'(data.x_value) - 18'(3 << (FRAC_BITS - 1)))), .term(ts));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sh_q <= '0;
			l_sh_q <= '0;
		end else begin
			v_sh_q <= {v_sh_q[LAT-2:0], acc};
			l_sh_q <= {l_sh_q[LAT-2:0], acc & data.is_last};
		end
	end

	// accumulate with saturation
	assign ap = 35'(sp_q) + 35'(tp);
	assign as_ = 35'(ss_q) + 35'(ts);
	always_comb begin
		sp_n = sp_q; ss_n = ss_q; cnt_n = cnt_q; sat_n = sat_q;
		if (cnt_q >= CNT_W'(MAX_VARS)) begin
			sat_n = 1'b1;
		end else begin
			sp_n = (ap > 35'hFFFFFFFF) ? '1 : ap[SUM_W-1:0];
			ss_n = (as_ > 35'hFFFFFFFF) ? '1 : as_[SUM_W-1:0];
			cnt_n = cnt_q + 1'b1;
		end
	end
	assign push = v_sh_q[LAT-1] & l_sh_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0; ss_q <= '0; cnt_q <= '0; sat_q <= 1'b0;
			fill_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
		end else begin
			if (v_sh_q[LAT-1]) begin
				if (push) begin
					sp_q <= '0; ss_q <= '0; cnt_q <= '0; sat_q <= 1'b0;
				end else begin
					sp_q <= sp_n; ss_q <= ss_n; cnt_q <= cnt_n; sat_q <= sat_n;
				end
			end
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			fill_q <= 2'(fill_q + 2'(push) - 2'(q_pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= '{sum_plain: sp_n, sum_shifted: ss_n,
			count: cnt_n, saturated: sat_n};
	end

	assign q_valid = (fill_q != 2'd0);
	assign q_data = ent_q[rd_q];
endmodule
`default_nettype wire

// ===== src/rtoe_back.sv =====
// Back end: divides both sums by the count (restoring, one bit a cycle), then
// takes both fourth roots by bit search, a square and a compare state per bit. Depends on rtoe_pkg.
`default_nettype none
module rtoe_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_valid,
	output logic                  q_pop,
	input  rtoe_pkg::vec_sums_t   q_data,
	output logic                  valid,
	input  wire                   stall,
	output rtoe_pkg::out_item_t   data
);
	import rtoe_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_SQ = 3'd2,
		ST_CMP = 3'd3, ST_OUT = 3'd4;

	logic [2:0]        st_q;
	logic [5:0]        cnt_q;
	logic [SUM_W-1:0]  nq_q [2];
	logic [CNT_W:0]    rem_q [2];
	logic [CNT_W-1:0]  den_q;
	logic              sat_q;
	logic [15:0]       o_q [2];
	logic [31:0]       c2_q [2];
	logic [3:0]        bit_q;
	logic [CNT_W:0]    rt [2];
	logic [15:0]       cand [2];
	logic [63:0]       c4 [2];
	logic [63:0]       hi [2];
	logic              ok [2];
	logic              out_v_q;
	out_item_t         out_q;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rt[i] = {rem_q[i][CNT_W-1:0], nq_q[i][SUM_W-1]};
			cand[i] = o_q[i] | (16'd1 << bit_q);
			c4[i] = 64'(c2_q[i]) * 64'(c2_q[i]);
			hi[i] = c4[i] >> ROOT_SH;
			ok[i] = (hi[i] < 64'(nq_q[i])) ||
				((hi[i] == 64'(nq_q[i])) && (c4[i][ROOT_SH-1:0] == '0));
		end
	end

	assign q_pop = (st_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			// result register: load a new result or drop the one taken
			if (st_q == ST_OUT && (!out_v_q || !stall)) out_v_q <= 1'b1;
			else if (!stall) out_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid) st_q <= ST_DIV;
				ST_DIV:  if (cnt_q == 6'd0) st_q <= ST_SQ;
				ST_SQ:   st_q <= ST_CMP;
				ST_CMP:  if (bit_q == 4'd0) st_q <= ST_OUT;
					else st_q <= ST_SQ;
				ST_OUT: if (!out_v_q || !stall) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				nq_q[0] <= q_data.sum_plain;
				nq_q[1] <= q_data.sum_shifted;
				rem_q[0] <= '0; rem_q[1] <= '0;
				den_q <= (q_data.count == '0) ? CNT_W'(1) : q_data.count;
				sat_q <= q_data.saturated;
				cnt_q <= 6'(SUM_W - 1);
				bit_q <= 4'd15;
				o_q[0] <= '0; o_q[1] <= '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				for (int i = 0; i < 2; i++) begin
					if (rt[i] >= {1'b0, den_q}) begin
						rem_q[i] <= rt[i] - {1'b0, den_q};
						nq_q[i] <= {nq_q[i][SUM_W-2:0], 1'b1};
					end else begin
						rem_q[i] <= rt[i];
						nq_q[i] <= {nq_q[i][SUM_W-2:0], 1'b0};
					end
				end
			end
			ST_SQ: for (int i = 0; i < 2; i++) c2_q[i] <= 32'(cand[i]) * 32'(cand[i]);
			ST_CMP: begin
				for (int i = 0; i < 2; i++) if (ok[i]) o_q[i] <= cand[i];
				bit_q <= bit_q - 1'b1;
			end
			ST_OUT: if (!out_v_q || !stall)
				out_q <= '{obj_first: o_q[0], obj_second: o_q[1], overflow: sat_q};
			default: ;
		endcase
	end

	assign valid = out_v_q;
	assign data = out_q;
endmodule
`default_nettype wire

// ===== src/rastrigin_two_objective_eval.sv =====
// Two-objective Rastrigin evaluator: streams variables one per cycle while not stalled
// and, on the item marked last, emits the fourth roots of the two mean terms with an
// overflow flag. Ordinary variables are taken every cycle the input is not stalled; a
// closing item passes the five-stage term pipeline, then the back end takes the vector,
// runs a bit-serial division and a 16-step root search (a square and a compare state per
// step) and loads the result. Input stalls while two closed vectors are queued or still
// in the term pipeline. Depends on rtoe_pkg, rtoe_front, rtoe_back.
`default_nettype none
module rastrigin_two_objective_eval (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  rtoe_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  wire                   out_stall,
	output rtoe_pkg::out_item_t   out_data
);
	import rtoe_pkg::*;

	logic      q_valid, q_pop;
	vec_sums_t q_data;

	rtoe_front u_front (.clk(clk), .arst_n(arst_n), .valid(in_valid),
		.stall(in_stall), .data(in_data), .q_valid(q_valid), .q_pop(q_pop),
		.q_data(q_data));

	rtoe_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid),
		.q_pop(q_pop), .q_data(q_data), .valid(out_valid), .stall(out_stall),
		.data(out_data));
endmodule
`default_nettype wire

// ===== src/rtoe_checker.sv =====
// Port-level checks for the evaluator, bound to the top level.
// Depends on rtoe_pkg.
`default_nettype none
module rtoe_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input rtoe_pkg::in_item_t  in_data,
	input wire                 out_valid,
	input wire                 out_stall,
	input rtoe_pkg::out_item_t out_data
);
	// a pending result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// an offered result carries known bits
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data))
		else $error("unknown result bits");
	// no result straight out of reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result after reset");
endmodule

bind rastrigin_two_objective_eval rtoe_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for rastrigin_two_objective_eval: streams decision-variable vectors and
// checks both objectives and the overflow flag against a bit-exact predictor.
// Depends on rtoe_pkg and the RTL of the evaluator.
`default_nettype none

class rtoe_scoreboard;
	// running vector state of the predictor
	bit [31:0] acc_plain;
	bit [31:0] acc_shifted;
	int unsigned n_vars;
	bit sat_flag;
	rtoe_pkg::out_item_t pending_objs[$];
	int unsigned n_mismatch;
	int unsigned n_checked;

	function void clear_vector();
		acc_plain = 0;
		acc_shifted = 0;
		n_vars = 0;
		sat_flag = 0;
	endfunction

	// cos(2*pi*y) in signed Q1.14
	function int cos_q14(longint y);
		longint unsigned fr;
		int unsigned p, q, r, u, u2, t, s;
		fr = y & ((64'd1 << rtoe_pkg::FRAC_BITS) - 1);
		p = int'(fr << (16 - rtoe_pkg::FRAC_BITS));
		p = (p + 16384) & 16'hFFFF;
		q = p >> 14;
		r = p & 16'h3FFF;
		u = q[0] ? (16384 - r) : r;
		u2 = (u * u) >> 14;
		t = 307;
		t = 5223 - ((u2 * t) >> 14);
		t = 42334 - ((u2 * t) >> 14);
		t = 102944 - int'((64'(u2) * t) >> 14);
		s = int'((64'(u) * t) >> 16);
		if (s > 16384)
			s = 16384;
		return (q >= 2) ? -int'(s) : int'(s);
	endfunction

	function longint unsigned term_of(longint y);
		longint unsigned mag, sq, wave;
		mag = (y < 0) ? -y : y;
		sq = (mag * mag) >> rtoe_pkg::FRAC_BITS;
		wave = 10 * (16384 - cos_q14(y));
		return sq + ((wave << rtoe_pkg::FRAC_BITS) >> 14);
	endfunction

	function bit [31:0] sat_add(bit [31:0] a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function bit [15:0] root4(longint unsigned mean);
		longint unsigned msk, cand, c4, hi;
		bit [15:0] o;
		msk = (64'd1 << rtoe_pkg::ROOT_SH) - 1;
		o = 0;
		for (int b = 15; b >= 0; b--) begin
			cand = o | (16'd1 << b);
			c4 = (cand * cand) * (cand * cand);
			hi = c4 >> rtoe_pkg::ROOT_SH;
			if (hi < mean || (hi == mean && (c4 & msk) == 0))
				o = cand[15:0];
		end
		return o;
	endfunction

	// note an accepted request and queue the objectives it closes
	function void note_request(rtoe_pkg::in_item_t it);
		longint x;
		int unsigned cnt;
		rtoe_pkg::out_item_t e;
		x = longint'(it.x_value);
		if (n_vars >= rtoe_pkg::MAX_VARS) begin
			sat_flag = 1;
		end else begin
			acc_plain = sat_add(acc_plain, term_of(x));
			acc_shifted = sat_add(acc_shifted,
				term_of(x - (64'sd3 <<< (rtoe_pkg::FRAC_BITS - 1))));
			n_vars++;
		end
		if (it.is_last) begin
			cnt = n_vars ? n_vars : 1;
			e.obj_first = root4(acc_plain / cnt);
			e.obj_second = root4(acc_shifted / cnt);
			e.overflow = sat_flag;
			pending_objs.push_back(e);
			clear_vector();
		end
	endfunction

	function void check_result(rtoe_pkg::out_item_t got);
		rtoe_pkg::out_item_t e;
		n_checked++;
		if (pending_objs.size() == 0) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("unexpected result %h with nothing pending", got);
			return;
		end
		e = pending_objs.pop_front();
		if (got !== e) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("mismatch: exp first=%h second=%h ovf=%b, got first=%h second=%h ovf=%b",
					e.obj_first, e.obj_second, e.overflow,
					got.obj_first, got.obj_second, got.overflow);
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rtoe_pkg::*;

	localparam int X_MAX = 20972;

	logic clk = 0;
	logic arst_n = 1;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1;
	out_item_t out_data;

	int send_idle_pct = 34;
	int recv_idle_pct = 84;
	bit hold_off = 0;
	int unsigned n_vectors = 0;
	int unsigned n_sent = 0;
	bit stim_done = 0;
	rtoe_scoreboard board = new();

	rastrigin_two_objective_eval dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// sample both handshakes
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_request(in_data);
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_data);
	end

	// receiver stall, randomised or held off
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1;
		else
			out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	// offer one request, idling beforehand at random
	task automatic send_request(logic signed [15:0] x, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{x_value: x, is_last: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
		if (last)
			n_vectors++;
	endtask

	function automatic logic signed [15:0] pick_x();
		case ($urandom_range(9))
			0: return -16'sd20972;
			1: return 16'sd20972;
			2: return 16'($urandom_range(65535));
			3: return 16'($signed($urandom_range(2 * 6144)) - 6144);
			default: return 16'($signed($urandom_range(2 * X_MAX)) - X_MAX);
		endcase
	endfunction

	task automatic send_vector(int len);
		for (int i = 0; i < len; i++)
			send_request(pick_x(), i == len - 1);
	endtask

	initial begin
		logic signed [15:0] dir_x[9] = '{-16'sd20972, 16'sd20972, 16'sd0, 16'sd6144,
			-16'sd32768, 16'sd32767, 16'sd4096, -16'sd1, 16'sd2048};
		int len;
		board.clear_vector();
		board.n_mismatch = 0;
		board.n_checked = 0;
		#1 arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single-variable vectors at the extremes and the optimum points
		foreach (dir_x[i])
			send_request(dir_x[i], 1);
		// two multi-variable vectors, one of them all at the most negative input value
		for (int i = 0; i < 5; i++)
			send_request(-16'sd32768, i == 4);
		send_vector(3);

		// random vectors, three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 84;
				recv_idle_pct = 34;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int v = 0; v < 35; v++) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
				send_vector(len);
			end
			// receiver holds off while short vectors keep arriving
			if (ph == 0) begin
				fork
					begin
						hold_off = 1;
						repeat (600) @(posedge clk);
						hold_off = 0;
					end
					for (int v = 0; v < 12; v++)
						send_vector($urandom_range(1, 3));
				join
			end
		end

		// count saturation: one vector just over the limit
		send_idle_pct = 0;
		send_vector(MAX_VARS + 3);
		in_valid <= 0;
		stim_done = 1;

		while (board.pending_objs.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d variables in %0d vectors and checked %0d results,",
			n_sent, n_vectors, board.n_checked);
		$display("covering field extremes, count saturation, stalls and a long hold-off.");
		if (board.n_mismatch == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
